/* design/tod_pkg.sv */
// ============================================================================
// Time-of-day counter package
// Operation codes, time constants and the pipeline word type shared by the
// 24-hour hour/minute/second counter.
// ============================================================================
package tod_pkg;

    // Operation carried with each input word.
    typedef enum logic [2:0] {
        OP_SET_ALL  = 3'd0,
        OP_LOAD     = 3'd1,
        OP_SET_HOUR = 3'd2,
        OP_SET_MIN  = 3'd3,
        OP_SET_SEC  = 3'd4,
        OP_INC      = 3'd5,
        OP_DEC      = 3'd6,
        OP_ADD      = 3'd7
    } op_t;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
    localparam logic [4:0]  HOUR_MAX      = 5'd23;
    localparam logic [5:0]  MIN_MAX       = 6'd59;
    localparam logic [5:0]  SEC_MAX       = 6'd59;

    // Reciprocals for the constant divisions.
    // floor(x / 86400) = floor((x >> 7) / 675), estimated with
    // floor(2^35 / 675); the estimate is low by at most one.
    localparam logic [25:0] DAY_RECIP  = 26'd50903316;
    // floor(r / 3600) = floor((r >> 4) / 225), exact for r < 86400.
    localparam logic [12:0] HOUR_RECIP = 13'd4661;
    // floor(r / 60) = floor((r >> 2) / 15), exact for r < 3600.
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    localparam int PIPE_DEPTH = 7;

    // One word moving down the offset pipeline. Later stages fill in
    // more of the fields.
    typedef struct packed {
        op_t                op;
        logic signed [7:0]  hour_in;
        logic signed [7:0]  minute_in;
        logic signed [7:0]  second_in;
        logic signed [31:0] count_in;
        logic               neg;    // offset is negative
        logic [31:0]        mag;    // magnitude of the second count
        logic [15:0]        quo;    // estimated days in mag
        logic [16:0]        total;  // offset reduced to 0..86399
        logic [4:0]         off_hour;
        logic [11:0]        rem;    // total minus whole hours
        logic [5:0]         off_min;
        logic [5:0]         off_sec;
    } stage_t;

endpackage

/* design/time_of_day_hms_counter.sv */
// ============================================================================
// 24-hour time-of-day counter
// Holds hour, minute and second and applies one set, load, step or offset
// operation per input word, returning the time after each operation.
// ============================================================================
// Each accepted word passes through the offset pipeline and then the time update.
// Throughput: one word per cycle; the seven-stage offset pipeline and the
// time update sustain this. Backpressure on the result side
// stalls the whole pipeline.
// Reset: asynchronous, active low; the time returns to 00:00:00 and the
// pipeline and result register are emptied.
module time_of_day_hms_counter
    import tod_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // hour_in[7:0], minute_in[15:8],
                                   // second_in[23:16], count_in[55:24]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hour_out[4:0], minute_out[10:5],
                                   // second_out[16:11], zero pad above
);

    // ------------------------------------------------------------------
    // The time itself is kept as hour, minute and second registers. Any
    // offset that comes from the count field (load or add) is first
    // reduced modulo one day and split into hours, minutes and seconds by
    // a pipeline that does not look at the time. Only the last step, a
    // mixed-radix add with carries, touches the time registers, so a new
    // word can enter every cycle while no result waits.
    // ------------------------------------------------------------------

    stage_t                  stage_reg  [PIPE_DEPTH];
    stage_t                  stage_next [PIPE_DEPTH];
    logic [PIPE_DEPTH-1:0]   vld_reg;
    logic [PIPE_DEPTH-1:0]   vld_next;
    logic                    out_vld_reg;
    logic                    out_vld_next;
    logic [4:0]              hour_reg;
    logic [4:0]              hour_next;
    logic [5:0]              minute_reg;
    logic [5:0]              minute_next;
    logic [5:0]              second_reg;
    logic [5:0]              second_next;

    logic                    adv;
    logic                    commit;

    // Datapath intermediates.
    logic [50:0]             day_prod;
    logic [32:0]             day_diff;
    logic [16:0]             day_rem;
    logic [25:0]             hour_prod;
    logic [16:0]             hour_rem;
    logic [20:0]             min_prod;
    logic [11:0]             sec_rem;

    // Update step.
    stage_t                  fin;
    logic [4:0]              add_hour;
    logic [5:0]              add_min;
    logic [5:0]              add_sec;
    logic [6:0]              sec_sum;
    logic [6:0]              min_sum;
    logic [5:0]              hr_sum;
    logic                    sec_carry;
    logic                    min_carry;
    logic [4:0]              step_hour;
    logic [5:0]              step_min;
    logic [5:0]              step_sec;
    logic                    hour_ok;
    logic                    min_ok;
    logic                    sec_ok;

    // The pipeline moves as one; it holds only while a result waits.
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign commit   = adv && vld_reg[PIPE_DEPTH-1];

    // ------------------------------------------------------------------
    // Offset pipeline
    // ------------------------------------------------------------------
    always_comb
    begin
        // Stage 0: capture the input word.
        stage_next[0]           = '0;
        stage_next[0].op        = op_t'(s_tuser);
        stage_next[0].hour_in   = s_tdata[7:0];
        stage_next[0].minute_in = s_tdata[15:8];
        stage_next[0].second_in = s_tdata[23:16];
        stage_next[0].count_in  = s_tdata[55:24];

        // Stage 1: magnitude and sign of the offset, then a day-count
        // estimate. A negative load count clamps to zero.
        stage_next[1] = stage_reg[0];
        if (stage_reg[0].op == OP_LOAD && stage_reg[0].count_in[31])
        begin
            stage_next[1].neg = 1'b0;
            stage_next[1].mag = '0;
        end
        else
        begin
            stage_next[1].neg = stage_reg[0].count_in[31];
            stage_next[1].mag = stage_reg[0].count_in[31]
                              ? (~stage_reg[0].count_in) + 32'd1
                              : stage_reg[0].count_in;
        end
        day_prod = 51'(stage_next[1].mag[31:7]) * 51'(DAY_RECIP);
        stage_next[1].quo = day_prod[50:35];

        // Stage 2: remainder with one correction, then mirror it for a
        // negative offset so the result lands in 0..86399.
        stage_next[2] = stage_reg[1];
        day_diff = {1'b0, stage_reg[1].mag} - 33'(stage_reg[1].quo) * 33'(SECS_PER_DAY);
        day_rem  = (day_diff >= 33'(SECS_PER_DAY))
                 ? 17'(day_diff - 33'(SECS_PER_DAY))
                 : day_diff[16:0];
        if (stage_reg[1].neg && day_rem != 17'd0)
        begin
            stage_next[2].total = SECS_PER_DAY - day_rem;
        end
        else
        begin
            stage_next[2].total = day_rem;
        end

        // Stage 3: whole hours of the offset.
        stage_next[3] = stage_reg[2];
        hour_prod = 26'(stage_reg[2].total[16:4]) * 26'(HOUR_RECIP);
        stage_next[3].off_hour = hour_prod[24:20];

        // Stage 4: seconds left within the hour.
        stage_next[4] = stage_reg[3];
        hour_rem = stage_reg[3].total
                 - 17'(stage_reg[3].off_hour) * 17'(SECS_PER_HOUR);
        stage_next[4].rem = hour_rem[11:0];

        // Stage 5: whole minutes within the hour.
        stage_next[5] = stage_reg[4];
        min_prod = 21'(stage_reg[4].rem[11:2]) * 21'(MIN_RECIP);
        stage_next[5].off_min = min_prod[19:14];

        // Stage 6: seconds left within the minute.
        stage_next[6] = stage_reg[5];
        sec_rem = stage_reg[5].rem - 12'(stage_reg[5].off_min) * 12'(SECS_PER_MIN);
        stage_next[6].off_sec = sec_rem[5:0];
    end

    always_comb
    begin
        vld_next = adv ? {vld_reg[PIPE_DEPTH-2:0], s_tvalid} : vld_reg;
    end

    // ------------------------------------------------------------------
    // Time update
    // ------------------------------------------------------------------
    always_comb
    begin
        fin = stage_reg[PIPE_DEPTH-1];

        case (fin.op)
            OP_INC:
            begin
                add_hour = 5'd0;
                add_min  = 6'd0;
                add_sec  = 6'd1;
            end
            // Stepping back one second is the same as adding 23:59:59.
            OP_DEC:
            begin
                add_hour = HOUR_MAX;
                add_min  = MIN_MAX;
                add_sec  = SEC_MAX;
            end
            default:
            begin
                add_hour = fin.off_hour;
                add_min  = fin.off_min;
                add_sec  = fin.off_sec;
            end
        endcase

        sec_sum   = 7'(second_reg) + 7'(add_sec);
        sec_carry = sec_sum >= 7'(SECS_PER_MIN);
        step_sec  = sec_carry ? 6'(sec_sum - 7'(SECS_PER_MIN)) : sec_sum[5:0];

        min_sum   = 7'(minute_reg) + 7'(add_min) + 7'(sec_carry);
        min_carry = min_sum >= 7'(MINS_PER_HOUR);
        step_min  = min_carry ? 6'(min_sum - 7'(MINS_PER_HOUR)) : min_sum[5:0];

        hr_sum    = 6'(hour_reg) + 6'(add_hour) + 6'(min_carry);
        step_hour = (hr_sum >= 6'(HOURS_PER_DAY))
                  ? 5'(hr_sum - 6'(HOURS_PER_DAY))
                  : hr_sum[4:0];

        hour_ok = !fin.hour_in[7]   && (fin.hour_in[6:0]   < 7'(HOURS_PER_DAY));
        min_ok  = !fin.minute_in[7] && (fin.minute_in[6:0] < 7'(MINS_PER_HOUR));
        sec_ok  = !fin.second_in[7] && (fin.second_in[6:0] < 7'(SECS_PER_MIN));
    end

    always_comb
    begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (commit)
        begin
            case (fin.op)
                OP_SET_ALL:
                begin
                    // Any field out of range clears the whole time.
                    if (hour_ok && min_ok && sec_ok)
                    begin
                        hour_next   = fin.hour_in[4:0];
                        minute_next = fin.minute_in[5:0];
                        second_next = fin.second_in[5:0];
                    end
                    else
                    begin
                        hour_next   = '0;
                        minute_next = '0;
                        second_next = '0;
                    end
                end
                OP_LOAD:
                begin
                    hour_next   = fin.off_hour;
                    minute_next = fin.off_min;
                    second_next = fin.off_sec;
                end
                OP_SET_HOUR:
                begin
                    if (hour_ok)
                    begin
                        hour_next = fin.hour_in[4:0];
                    end
                end
                OP_SET_MIN:
                begin
                    if (min_ok)
                    begin
                        minute_next = fin.minute_in[5:0];
                    end
                end
                OP_SET_SEC:
                begin
                    if (sec_ok)
                    begin
                        second_next = fin.second_in[5:0];
                    end
                end
                default:
                begin
                    hour_next   = step_hour;
                    minute_next = step_min;
                    second_next = step_sec;
                end
            endcase
        end
    end

    always_comb
    begin
        out_vld_next = adv ? vld_reg[PIPE_DEPTH-1] : out_vld_reg;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
        end
        else
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
        end
    end

    // The time registers double as the result register: while a result
    // waits, the pipeline is held and the time cannot move.
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, second_reg, minute_reg, hour_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_time_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (hour_reg < HOURS_PER_DAY) && (minute_reg < MINS_PER_HOUR)
        && (second_reg < SECS_PER_MIN))
        else $error("time registers out of range");

    a_time_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable({hour_reg, minute_reg, second_reg}))
        else $error("time changed without a word completing");

    a_result_from_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[PIPE_DEPTH-1]))
        else $error("result valid without a word in the last stage");

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

endmodule

/* tb/sv/tb_time_of_day_hms_counter.sv */
// ============================================================================
// Testbench for the 24-hour time-of-day counter
// Drives operation words into the counter and checks every returned time
// word against a behavioral copy of the hour/minute/second state. A short
// directed sequence covers the midnight wraps, out-of-range set values and
// the extremes of the second count. Four random phases follow, with
// different amounts of sender idling and receiver backpressure.
// ============================================================================
module tb_time_of_day_hms_counter;
    import tod_pkg::*;

    // Time constants as signed 64-bit values, so that the arithmetic on
    // negative second counts stays signed.
    localparam longint DAY_SECS  = longint'(SECS_PER_DAY);
    localparam longint HOUR_SECS = longint'(SECS_PER_HOUR);
    localparam longint MIN_SECS  = longint'(SECS_PER_MIN);
    localparam int     MAX_SHOWN = 10;

    typedef struct {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    // Keeps its own copy of the clock, advances it for every accepted
    // operation word and holds the times the counter should return, in order.
    class tod_scoreboard;
        logic [4:0] hour_q;
        logic [5:0] minute_q;
        logic [5:0] second_q;
        hms_t       expected_times[$];
        int         failures;
        int         shown;

        function new();
            hour_q   = '0;
            minute_q = '0;
            second_q = '0;
            failures = 0;
            shown    = 0;
        endfunction

        function longint seconds_of_day();
            return longint'(hour_q) * HOUR_SECS + longint'(minute_q) * MIN_SECS
                   + longint'(second_q);
        endfunction

        // Reduces any total, however far below zero, into one day and splits it.
        function void set_from_total(longint total);
            longint r;
            r = total % DAY_SECS;
            if (r < 0)
                r += DAY_SECS;
            hour_q   = 5'(r / HOUR_SECS);
            minute_q = 6'((r % HOUR_SECS) / MIN_SECS);
            second_q = 6'(r % MIN_SECS);
        endfunction

        function void note_word(op_t op, logic signed [7:0] h, logic signed [7:0] m,
                                logic signed [7:0] s, logic signed [31:0] c);
            bit h_ok;
            bit m_ok;
            bit s_ok;
            h_ok = (h >= 0) && (h < 24);
            m_ok = (m >= 0) && (m < 60);
            s_ok = (s >= 0) && (s < 60);
            case (op)
                OP_SET_ALL:
                begin
                    // One bad field clears the whole time.
                    if (h_ok && m_ok && s_ok)
                    begin
                        hour_q   = h[4:0];
                        minute_q = m[5:0];
                        second_q = s[5:0];
                    end
                    else
                    begin
                        hour_q   = '0;
                        minute_q = '0;
                        second_q = '0;
                    end
                end
                OP_LOAD:     set_from_total((c < 0) ? 64'sd0 : longint'(c));
                OP_SET_HOUR: if (h_ok) hour_q = h[4:0];
                OP_SET_MIN:  if (m_ok) minute_q = m[5:0];
                OP_SET_SEC:  if (s_ok) second_q = s[5:0];
                OP_INC:      set_from_total(seconds_of_day() + 1);
                OP_DEC:      set_from_total(seconds_of_day() - 1);
                default:     set_from_total(seconds_of_day() + longint'(c));
            endcase
            expected_times.push_back('{hour_q, minute_q, second_q});
        endfunction

        function void check_word(logic [23:0] word);
            hms_t got;
            hms_t want;
            got.hour   = word[4:0];
            got.minute = word[10:5];
            got.second = word[16:11];
            if (expected_times.size() == 0)
            begin
                failures++;
                if (shown < MAX_SHOWN)
                begin
                    shown++;
                    $display("unexpected time word %0d:%0d:%0d with nothing outstanding",
                             got.hour, got.minute, got.second);
                end
                return;
            end
            want = expected_times.pop_front();
            if (got.hour !== want.hour || got.minute !== want.minute
                || got.second !== want.second)
            begin
                failures++;
                if (shown < MAX_SHOWN)
                begin
                    shown++;
                    $display("time mismatch: expected %0d:%0d:%0d, got %0d:%0d:%0d",
                             want.hour, want.minute, want.second,
                             got.hour, got.minute, got.second);
                end
            end
        endfunction

        function int pending();
            return expected_times.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;      // hour_in, minute_in, second_in, count_in
    logic [2:0]  s_tuser = OP_SET_ALL;  // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // hour_out, minute_out, second_out, pad

    int unsigned   send_idle_pct = 0;
    int unsigned   stall_pct = 0;
    tod_scoreboard sb;

    time_of_day_hms_counter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // The result side stalls at random; the rate follows the current phase.
    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);

    // Called at a falling edge; returns at the falling edge after the word
    // has been taken, with valid still high so that words can go back to back.
    task automatic send_word(input op_t op, input logic [7:0] h, input logic [7:0] m,
                             input logic [7:0] s, input logic [31:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {c, s, m, h};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(op, h, m, s, c);
        @(negedge clk);
    endtask

    // Mostly in-range values, with the full signed byte range a quarter of
    // the time so that every bit and the invalid cases show up.
    function automatic logic [7:0] pick_field(int unsigned top);
        if ($urandom_range(3) != 0)
            return 8'($urandom_range(top));
        return 8'($urandom_range(255));
    endfunction

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input int words);
        op_t         op;
        logic [7:0]  h;
        logic [7:0]  m;
        logic [7:0]  s;
        logic [31:0] c;
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (words)
        begin
            op = op_t'($urandom_range(7));
            h  = pick_field(23);
            m  = pick_field(59);
            s  = pick_field(59);
            case ($urandom_range(2))
                0:       c = 32'($urandom_range(400)) - 32'd200;
                1:       c = 32'($urandom_range(6 * 86400)) - 32'd259200;
                default: c = $urandom();
            endcase
            // Park the clock close to midnight now and then, so that steps
            // and small offsets keep crossing the day boundary.
            if (op == OP_SET_ALL && $urandom_range(2) == 0)
            begin
                h = 8'd23;
                m = 8'd59;
                s = 8'($urandom_range(55, 59));
            end
            send_word(op, h, m, s, c);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words with no idling on either side.
        send_word(OP_SET_ALL, 8'd23, 8'd59, 8'd59, 32'd0);
        send_word(OP_INC, 8'h80, 8'h7f, 8'hff, 32'hffff_ffff);   // forward through midnight
        send_word(OP_DEC, 8'd0, 8'd0, 8'd0, 32'd0);              // back through midnight
        send_word(OP_SET_ALL, 8'd24, 8'd0, 8'd0, 32'd5);         // hour too large
        send_word(OP_SET_ALL, 8'd23, 8'd59, 8'd59, 32'd0);
        send_word(OP_SET_ALL, 8'd0, 8'd60, 8'd0, 32'd0);         // minute too large
        send_word(OP_SET_ALL, 8'd10, 8'd20, 8'd30, 32'd0);
        send_word(OP_SET_ALL, 8'h80, 8'h7f, 8'hff, 32'd0);       // all fields bad
        send_word(OP_DEC, 8'd0, 8'd0, 8'd0, 32'd0);
        send_word(OP_LOAD, 8'd0, 8'd0, 8'd0, 32'hffff_ffff);     // negative load
        send_word(OP_LOAD, 8'd0, 8'd0, 8'd0, 32'h8000_0000);
        send_word(OP_LOAD, 8'd0, 8'd0, 8'd0, 32'h7fff_ffff);     // many days
        send_word(OP_LOAD, 8'd0, 8'd0, 8'd0, 32'd86399);
        send_word(OP_LOAD, 8'd0, 8'd0, 8'd0, 32'd86400);         // exactly one day
        send_word(OP_SET_HOUR, 8'd23, 8'd99, 8'd99, 32'd0);
        send_word(OP_SET_HOUR, 8'd24, 8'd0, 8'd0, 32'd0);        // ignored
        send_word(OP_SET_HOUR, 8'hff, 8'd0, 8'd0, 32'd0);        // ignored
        send_word(OP_SET_MIN, 8'd0, 8'd59, 8'd0, 32'd0);
        send_word(OP_SET_MIN, 8'd0, 8'd60, 8'd0, 32'd0);         // ignored
        send_word(OP_SET_SEC, 8'd0, 8'd0, 8'd59, 32'd0);
        send_word(OP_SET_SEC, 8'd0, 8'd0, 8'h80, 32'd0);         // ignored
        send_word(OP_ADD, 8'd0, 8'd0, 8'd0, 32'h7fff_ffff);
        send_word(OP_ADD, 8'd0, 8'd0, 8'd0, 32'h8000_0000);      // far below zero
        send_word(OP_ADD, 8'd0, 8'd0, 8'd0, 32'hfffe_ae7f);      // minus a day and one
        send_word(OP_ADD, 8'd0, 8'd0, 8'd0, 32'd0);

        run_phase(0, 0, 300);
        run_phase(68, 0, 300);
        run_phase(0, 68, 300);
        run_phase(13, 13, 300);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // Any stray word would arrive within the pipeline latency.
        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
